// ===== sv/eipl4_pkg.sv =====
package eipl4_pkg;

  // default width of the saturating byte counter
  localparam int COUNT_BITS_DEF = 16;

  // ethertypes
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86dd;

  // ip protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // header sizes and offsets in bytes
  localparam int ETH_HDR_LEN   = 14;
  localparam int IPV4_MIN_END  = 34;
  localparam int IPV4_MIN_HLEN = 20;
  localparam int TCP_MIN_HLEN  = 20;
  localparam int UDP_HLEN      = 8;

  typedef enum logic [3:0] {
    CLS_SHORT      = 4'd0,
    CLS_V4TRUNC    = 4'd1,
    CLS_V4BADHDR   = 4'd2,
    CLS_TCP        = 4'd3,
    CLS_TCPTRUNC   = 4'd4,
    CLS_UDP        = 4'd5,
    CLS_UDPTRUNC   = 4'd6,
    CLS_ICMP       = 4'd7,
    CLS_OTHERPROTO = 4'd8,
    CLS_IPV6       = 4'd9,
    CLS_ARP        = 4'd10,
    CLS_OTHERTYPE  = 4'd11
  } class_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    class_t      class_code;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] frame_type;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [7:0]  proto_num;
    logic [15:0] source_port;
    logic [15:0] dst_port;
    logic [15:0] payload_length;
    logic [5:0]  tcp_flag_set;
  } out_item_t;

  // header fields collected over one frame
  typedef struct packed {
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] frame_type;
    logic [3:0]  ihl;
    logic [15:0] ip_len;
    logic [7:0]  proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [3:0]  tcp_off;
    logic [5:0]  flags;
    logic [15:0] udp_len;
  } hdr_t;

endpackage

// ===== sv/eipl4_capture.sv =====
module eipl4_capture #(
  parameter int COUNT_BITS = eipl4_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  eipl4_pkg::in_item_t   item,
  output eipl4_pkg::hdr_t       fields_next,
  output logic [COUNT_BITS-1:0] caplen
);
  import eipl4_pkg::*;

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [COUNT_BITS-1:0] pos;
  hdr_t                  fields;
  logic [6:0]            l4_start;
  logic [COUNT_BITS-1:0] rel;
  logic [7:0]            b;

  // field capture at the current byte position
  always_comb begin
    b           = item.data_byte;
    fields_next = fields;
    l4_start    = 7'(ETH_HDR_LEN) + {1'b0, fields.ihl, 2'b00};
    rel         = pos - COUNT_BITS'(l4_start);

    if (pos < COUNT_BITS'(6)) begin
      fields_next.dst_mac = {fields.dst_mac[39:0], b};
    end else if (pos < COUNT_BITS'(12)) begin
      fields_next.src_mac = {fields.src_mac[39:0], b};
    end else if (pos < COUNT_BITS'(ETH_HDR_LEN)) begin
      fields_next.frame_type = {fields.frame_type[7:0], b};
    end else if (pos == COUNT_BITS'(14)) begin
      fields_next.ihl = b[3:0];
    end else if (pos == COUNT_BITS'(16) || pos == COUNT_BITS'(17)) begin
      fields_next.ip_len = {fields.ip_len[7:0], b};
    end else if (pos == COUNT_BITS'(23)) begin
      fields_next.proto = b;
    end else if (pos >= COUNT_BITS'(26) && pos < COUNT_BITS'(30)) begin
      fields_next.src_ip = {fields.src_ip[23:0], b};
    end else if (pos >= COUNT_BITS'(30) && pos < COUNT_BITS'(IPV4_MIN_END)) begin
      fields_next.dst_ip = {fields.dst_ip[23:0], b};
    end

    // transport header, placed by the ip header length
    if (pos >= COUNT_BITS'(IPV4_MIN_END) && pos >= COUNT_BITS'(l4_start)) begin
      if (rel < COUNT_BITS'(2)) begin
        fields_next.sport = {fields.sport[7:0], b};
      end else if (rel < COUNT_BITS'(4)) begin
        fields_next.dport = {fields.dport[7:0], b};
      end else if (rel < COUNT_BITS'(6)) begin
        fields_next.udp_len = {fields.udp_len[7:0], b};
      end else if (rel == COUNT_BITS'(12)) begin
        fields_next.tcp_off = b[7:4];
      end else if (rel == COUNT_BITS'(13)) begin
        fields_next.flags = b[5:0];
      end
    end

    // saturating count including this byte
    caplen = (pos == CountMax) ? pos : pos + COUNT_BITS'(1);
  end

  // frame state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      fields <= '0;
    end else if (take) begin
      if (item.last_byte) begin
        pos    <= '0;
        fields <= '0;
      end else begin
        pos    <= caplen;
        fields <= fields_next;
      end
    end
  end

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    take && item.last_byte |=> pos == '0 && fields == '0)
    else $error("frame state not cleared after last byte");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    take && !item.last_byte && pos != CountMax |=> pos == $past(pos) + COUNT_BITS'(1))
    else $error("byte counter did not advance");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(pos) && $stable(fields))
    else $error("frame state changed without a byte");

endmodule

// ===== sv/eipl4_classify.sv =====
module eipl4_classify #(
  parameter int COUNT_BITS = eipl4_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  stage_valid,
  input  logic                  stage_last,
  input  eipl4_pkg::hdr_t       fields,
  input  logic [COUNT_BITS-1:0] caplen,
  input  logic                  result_stall,
  output logic                  advance,
  output logic                  result_valid,
  output eipl4_pkg::out_item_t  result_item
);
  import eipl4_pkg::*;

  out_item_t  res;
  logic [5:0] hlen;
  logic [6:0] l4_start;
  logic [6:0] tcp_end;
  logic [6:0] udp_end;
  logic [6:0] tcp_hdrs;
  logic [16:0] tcp_diff;
  logic [16:0] ip_diff;
  logic [16:0] udp_diff;

  assign advance = !result_valid || !result_stall;

  // classify the finished frame
  always_comb begin
    res      = '0;
    hlen     = {fields.ihl, 2'b00};
    l4_start = 7'(ETH_HDR_LEN) + {1'b0, hlen};
    tcp_end  = l4_start + 7'(TCP_MIN_HLEN);
    udp_end  = l4_start + 7'(UDP_HLEN);
    tcp_hdrs = {1'b0, hlen} + {1'b0, fields.tcp_off, 2'b00};
    tcp_diff = {1'b0, fields.ip_len} - {10'd0, tcp_hdrs};
    ip_diff  = {1'b0, fields.ip_len} - {11'd0, hlen};
    udp_diff = {1'b0, fields.udp_len} - 17'(UDP_HLEN);

    res.class_code = CLS_SHORT;
    if (caplen >= COUNT_BITS'(ETH_HDR_LEN)) begin
      res.dest_mac   = fields.dst_mac;
      res.source_mac = fields.src_mac;
      res.frame_type = fields.frame_type;
      if (fields.frame_type == ETYPE_IPV4) begin
        if (caplen < COUNT_BITS'(IPV4_MIN_END)) begin
          res.class_code = CLS_V4TRUNC;
        end else begin
          res.source_addr = fields.src_ip;
          res.dest_addr   = fields.dst_ip;
          res.proto_num   = fields.proto;
          if (hlen < 6'(IPV4_MIN_HLEN) || caplen < COUNT_BITS'(l4_start)) begin
            res.class_code = CLS_V4BADHDR;
          end else if (fields.proto == PROTO_TCP) begin
            if (caplen < COUNT_BITS'(tcp_end)) begin
              res.class_code = CLS_TCPTRUNC;
            end else begin
              res.class_code     = CLS_TCP;
              res.source_port    = fields.sport;
              res.dst_port       = fields.dport;
              res.payload_length = tcp_diff[16] ? 16'd0 : tcp_diff[15:0];
              res.tcp_flag_set   = fields.flags;
            end
          end else if (fields.proto == PROTO_UDP) begin
            if (caplen < COUNT_BITS'(udp_end)) begin
              res.class_code = CLS_UDPTRUNC;
            end else begin
              res.class_code     = CLS_UDP;
              res.source_port    = fields.sport;
              res.dst_port       = fields.dport;
              res.payload_length = udp_diff[16] ? 16'd0 : udp_diff[15:0];
            end
          end else begin
            res.class_code     = (fields.proto == PROTO_ICMP) ? CLS_ICMP : CLS_OTHERPROTO;
            res.payload_length = ip_diff[16] ? 16'd0 : ip_diff[15:0];
          end
        end
      end else if (fields.frame_type == ETYPE_IPV6) begin
        res.class_code = CLS_IPV6;
      end else if (fields.frame_type == ETYPE_ARP) begin
        res.class_code = CLS_ARP;
      end else begin
        res.class_code = CLS_OTHERTYPE;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid && stage_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_item <= res;
    end
  end

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid == $past(stage_valid && stage_last))
    else $error("result valid does not follow a last byte");

  a_flags_tcp_only: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.class_code != CLS_TCP |-> result_item.tcp_flag_set == '0)
    else $error("tcp flags reported on a non-tcp frame");

  a_short_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.class_code == CLS_SHORT
      |-> result_item.dest_mac == '0 && result_item.frame_type == '0
          && result_item.payload_length == '0)
    else $error("short frame carries header fields");

endmodule

// ===== sv/eth_ipv4_l4_header_parser.sv =====
// Ethernet/IPv4/TCP/UDP header parser. Frame bytes enter on the byte channel
// one per transaction, in wire order, with last_byte set on the final
// captured byte; one result transaction follows each last byte and carries
// the class code, the MACs, ethertype, IPv4 addresses and protocol, the L4
// ports and flags and the payload length, with fields not reached given as
// zero. The block takes one byte every cycle while the result register is not
// held; a byte goes through the input register, then header capture and
// classification in one pass, into the result register. A held result stalls
// the byte channel in the same cycle. Frames longer than 2**COUNT_BITS - 1
// bytes are counted as that length.
module eth_ipv4_l4_header_parser #(
  parameter int COUNT_BITS = eipl4_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  eipl4_pkg::in_item_t  byte_item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output eipl4_pkg::out_item_t result_item
);
  import eipl4_pkg::*;

  logic                  advance;
  logic                  stage_valid;
  in_item_t              stage_item;
  logic                  take;
  hdr_t                  fields_next;
  logic [COUNT_BITS-1:0] caplen;

  assign byte_stall = !advance;
  assign take       = advance && stage_valid;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (advance) begin
      stage_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_item <= byte_item;
    end
  end

  eipl4_capture #(
    .COUNT_BITS (COUNT_BITS)
  ) u_capture (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .item        (stage_item),
    .fields_next (fields_next),
    .caplen      (caplen)
  );

  eipl4_classify #(
    .COUNT_BITS (COUNT_BITS)
  ) u_classify (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .stage_last   (stage_item.last_byte),
    .fields       (fields_next),
    .caplen       (caplen),
    .result_stall (result_stall),
    .advance      (advance),
    .result_valid (result_valid),
    .result_item  (result_item)
  );

endmodule
